>>> hdl/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg
// shared widths, constants, register indexes and lane result type
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int BTN_W       = 16;
  localparam int AXIS_W      = 16;
  localparam int LVL_W       = 15;
  localparam int DZ_W        = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_NUM_W   = 32;
  localparam int DIV_DEN_W   = 16;

  localparam logic [LVL_W-1:0] FULL_SCALE = 15'h7fff;
  localparam logic [DZ_W-1:0]  STICK_DZ_RST = 15'd6554;
  localparam logic [DZ_W-1:0]  TRIG_DZ_RST  = 15'd3277;

  // buttons above NUM_BUTTONS are dropped
  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_DZ = 2'd0,
    CFG_TRIG_DZ  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] sx;
    logic signed [AXIS_W-1:0] sy;
    logic [LVL_W-1:0]         trig;
  } lane_res_t;

  // magnitude of a raw axis after saturating -32768 to -32767
  function automatic logic [LVL_W-1:0] sat_abs(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] n;
    begin
      n = AXIS_W'(-v);
      if (v == 16'sh8000) return FULL_SCALE;
      else if (v[AXIS_W-1]) return n[LVL_W-1:0];
      else return v[LVL_W-1:0];
    end
  endfunction

  // x * 32767 as shift and subtract
  function automatic logic [DIV_NUM_W-1:0] times_fs(input logic [DIV_DEN_W-1:0] x);
    begin
      return ({16'd0, x} << 15) - {16'd0, x};
    end
  endfunction

endpackage

>>> hdl/gic_if.sv
// ----------------------------------------------------------------------------
// gic channel interfaces
// poll input, conditioned result and configuration write channels
// ----------------------------------------------------------------------------
interface gic_in_if;
  import gic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [BTN_W-1:0]         button_bits;
  logic signed [AXIS_W-1:0] raw_left_x;
  logic signed [AXIS_W-1:0] raw_left_y;
  logic signed [AXIS_W-1:0] raw_right_x;
  logic signed [AXIS_W-1:0] raw_right_y;
  logic signed [AXIS_W-1:0] raw_trigger_left;
  logic signed [AXIS_W-1:0] raw_trigger_right;
  modport source(output valid, action, button_bits, raw_left_x, raw_left_y, raw_right_x,
                 raw_right_y, raw_trigger_left, raw_trigger_right, input ready);
  modport sink(input valid, action, button_bits, raw_left_x, raw_left_y, raw_right_x,
               raw_right_y, raw_trigger_left, raw_trigger_right, output ready);
endinterface

interface gic_out_if;
  import gic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BTN_W-1:0]         held_mask;
  logic [BTN_W-1:0]         pressed_mask;
  logic [BTN_W-1:0]         released_mask;
  logic signed [AXIS_W-1:0] left_stick_x;
  logic signed [AXIS_W-1:0] left_stick_y;
  logic signed [AXIS_W-1:0] right_stick_x;
  logic signed [AXIS_W-1:0] right_stick_y;
  logic [LVL_W-1:0]         left_trigger_level;
  logic [LVL_W-1:0]         right_trigger_level;
  modport source(output valid, held_mask, pressed_mask, released_mask, left_stick_x,
                 left_stick_y, right_stick_x, right_stick_y, left_trigger_level,
                 right_trigger_level, input ready);
  modport sink(input valid, held_mask, pressed_mask, released_mask, left_stick_x,
               left_stick_y, right_stick_x, right_stick_y, left_trigger_level,
               right_trigger_level, output ready);
endinterface

interface gic_cfg_if;
  import gic_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DZ_W-1:0]      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/gic_div.sv
// ----------------------------------------------------------------------------
// gic_div
// restoring divider, one quotient bit a cycle, round half up on the result
// ----------------------------------------------------------------------------
module gic_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gic_pkg::DIV_NUM_W-1:0]  num,
  input  logic [gic_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [gic_pkg::DIV_NUM_W-1:0]  quo
);
  import gic_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic                 rnd;

  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  // remainder at least half the divisor rounds up
  assign rnd    = {rem_r, 1'b0} >= {1'b0, den_r};
  assign quo    = num_r + DIV_NUM_W'(rnd);
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[DIV_NUM_W-2:0], ge};
        rem_r <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/gic_lane.sv
// ----------------------------------------------------------------------------
// gic_lane
// one stick pair and one trigger: axial deadzones, root, radial deadzone
// ----------------------------------------------------------------------------
module gic_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gic_pkg::AXIS_W-1:0] raw_x,
  input  logic signed [gic_pkg::AXIS_W-1:0] raw_y,
  input  logic signed [gic_pkg::AXIS_W-1:0] raw_t,
  input  logic [gic_pkg::DZ_W-1:0]          stick_dz,
  input  logic [gic_pkg::DZ_W-1:0]          trig_dz,
  output logic                              done,
  output gic_pkg::lane_res_t                res
);
  import gic_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_DIV_T, ST_SQUARE, ST_SUM, ST_ROOT, ST_ROUND,
    ST_DIV_S, ST_SCALE, ST_DIV_CX, ST_DIV_CY
  } state_t;

  state_t               state_r;
  logic                 issued_r;
  logic                 done_r;
  lane_res_t            res_r;
  logic [LVL_W-1:0]     ax_r, ay_r, at_r;
  logic                 sgx_r, sgy_r;
  logic [DZ_W-1:0]      dzs_r, dzt_r;
  logic [LVL_W-1:0]     mx_r, my_r, cx_r;
  logic [LVL_W-1:0]     trig_r;
  logic [29:0]          sqx_r, sqy_r, dd_r, px_r, py_r;
  logic                 zero_r;
  logic [30:0]          rx_r, bit_r;
  logic [31:0]          root_r;
  logic [3:0]           iter_r;
  logic [DIV_DEN_W-1:0] m_r;
  logic [LVL_W-1:0]     s_r;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, stick_den, trig_den, m_den;
  logic [LVL_W-1:0]     q_clamp;
  logic [31:0]          trial;
  logic [30:0]          sq_sum;
  logic [DIV_DEN_W-1:0] m_diff;

  gic_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // full deadzone gives a zero divisor: divide by one, numerator or result is forced
  assign stick_den = (dzs_r == FULL_SCALE) ? 16'd1 : {1'b0, FULL_SCALE - dzs_r};
  assign trig_den  = (dzt_r == FULL_SCALE) ? 16'd1 : {1'b0, FULL_SCALE - dzt_r};
  assign m_den     = (m_r == '0) ? 16'd1 : m_r;
  assign q_clamp   = (div_quo > DIV_NUM_W'(FULL_SCALE)) ? FULL_SCALE : div_quo[LVL_W-1:0];
  assign trial     = root_r + {1'b0, bit_r};
  assign sq_sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign m_diff    = (m_r > {1'b0, dzs_r}) ? m_r - {1'b0, dzs_r} : '0;
  assign div_start = !issued_r && (state_r == ST_DIV_X || state_r == ST_DIV_Y ||
                     state_r == ST_DIV_T || state_r == ST_DIV_S ||
                     state_r == ST_DIV_CX || state_r == ST_DIV_CY);
  assign done      = done_r;
  assign res       = res_r;

  always_comb begin
    div_num = '0;
    div_den = 16'd1;
    unique case (state_r)
      ST_DIV_X: begin
        div_den = stick_den;
        if (ax_r >= dzs_r && dzs_r != FULL_SCALE) div_num = times_fs({1'b0, ax_r - dzs_r});
      end
      ST_DIV_Y: begin
        div_den = stick_den;
        if (ay_r >= dzs_r && dzs_r != FULL_SCALE) div_num = times_fs({1'b0, ay_r - dzs_r});
      end
      ST_DIV_T: begin
        div_den = trig_den;
        if (at_r >= dzt_r && dzt_r != FULL_SCALE) div_num = times_fs({1'b0, at_r - dzt_r});
      end
      ST_DIV_S: begin
        div_den = stick_den;
        div_num = times_fs(m_diff);
      end
      ST_DIV_CX: begin
        div_den = m_den;
        div_num = {2'b0, px_r};
      end
      ST_DIV_CY: begin
        div_den = m_den;
        div_num = {2'b0, py_r};
      end
      default: begin
        div_num = '0;
        div_den = 16'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_start) issued_r <= 1'b1;
      if (div_done) issued_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            ax_r    <= sat_abs(raw_x);
            ay_r    <= sat_abs(raw_y);
            sgx_r   <= raw_x[AXIS_W-1];
            sgy_r   <= raw_y[AXIS_W-1];
            // trigger map (n + 32768) >> 1, taken while the item is on the bus
            at_r    <= sat_abs(raw_t) == '0 ? 15'd16384 :
                       (raw_t[AXIS_W-1] ?
                        LVL_W'((17'd32768 - {2'b0, sat_abs(raw_t)}) >> 1) :
                        LVL_W'((17'd32768 + {2'b0, sat_abs(raw_t)}) >> 1));
            dzs_r   <= stick_dz;
            dzt_r   <= trig_dz;
            state_r <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          if (div_done) begin
            mx_r    <= q_clamp;
            state_r <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_done) begin
            my_r    <= q_clamp;
            state_r <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            trig_r  <= q_clamp;
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sqx_r   <= 30'(mx_r) * 30'(mx_r);
          sqy_r   <= 30'(my_r) * 30'(my_r);
          dd_r    <= 30'(dzs_r) * 30'(dzs_r);
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          zero_r  <= sq_sum < {1'b0, dd_r};
          rx_r    <= sq_sum;
          root_r  <= '0;
          bit_r   <= 31'h4000_0000;
          iter_r  <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if ({1'b0, rx_r} >= trial) begin
            rx_r   <= rx_r - trial[30:0];
            root_r <= (root_r >> 1) + {1'b0, bit_r};
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          iter_r <= iter_r + 4'd1;
          if (iter_r == 4'd15) state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          // remainder above the root rounds the root up
          m_r     <= DIV_DEN_W'(root_r + 32'({1'b0, rx_r} > root_r));
          state_r <= ST_DIV_S;
        end
        ST_DIV_S: begin
          if (div_done) begin
            if (dzs_r == FULL_SCALE) s_r <= (m_r > {1'b0, dzs_r}) ? FULL_SCALE : '0;
            else s_r <= q_clamp;
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          px_r    <= 30'(mx_r) * 30'(s_r);
          py_r    <= 30'(my_r) * 30'(s_r);
          state_r <= ST_DIV_CX;
        end
        ST_DIV_CX: begin
          if (div_done) begin
            cx_r    <= q_clamp;
            state_r <= ST_DIV_CY;
          end
        end
        ST_DIV_CY: begin
          if (div_done) begin
            res_r.trig <= trig_r;
            if (zero_r || m_r == '0) begin
              res_r.sx <= '0;
              res_r.sy <= '0;
            end else begin
              res_r.sx <= sgx_r ? -$signed({1'b0, cx_r}) : $signed({1'b0, cx_r});
              res_r.sy <= sgy_r ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
            end
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/gamepad_input_conditioner.sv
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// button edge masks plus axial, radial and trigger deadzones on gamepad polls
// ----------------------------------------------------------------------------
//  channel  | kind          | accepted when
//  in_ch    | poll item     | in_ch.valid & in_ch.ready
//  out_ch   | result item   | out_ch.valid & out_ch.ready
//  cfg_ch   | deadzone wr   | cfg_ch.valid & cfg_ch.ready (always ready)
//
// each item runs the six divisions of each lane
// through its one bit-serial divider plus a 16 step square root
// two lanes run side by side: left stick with left trigger, right with right
// the next item is taken once the lanes are free, even while a result waits
// in the output register; a stalled output holds the lanes' handoff
// synchronous active-low reset clears control and held buttons and loads the
// default deadzones
// ----------------------------------------------------------------------------
module gamepad_input_conditioner (
  input logic       clk,
  input logic       rst_n,
  gic_in_if.sink    in_ch,
  gic_out_if.source out_ch,
  gic_cfg_if.sink   cfg_ch
);
  import gic_pkg::*;

  // deadzone registers
  logic [DZ_W-1:0]  stick_dz_r, trig_dz_r;
  // held mask of the last item
  logic [BTN_W-1:0] prev_btn_r;

  // item in flight
  logic             busy_r;
  logic [1:0]       lane_done_r;
  logic             disc_r;
  logic [BTN_W-1:0] held_r, pressed_r, released_r;

  // output register
  logic             out_valid_r;
  logic [BTN_W-1:0] o_held_r, o_pressed_r, o_released_r;
  lane_res_t        o_left_r, o_right_r;

  logic             in_acc;
  logic [BTN_W-1:0] held_nxt;
  logic [1:0]       lane_done;
  logic [1:0]       done_nxt;
  logic             merge;
  lane_res_t        left_res, right_res;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign held_nxt  = in_ch.button_bits & BTN_MASK;
  assign done_nxt  = lane_done_r | lane_done;
  // both lanes finished and the output register free or draining
  assign merge     = busy_r && (&done_nxt) && (!out_valid_r || out_ch.ready);

  gic_lane u_lane_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .raw_x   (in_ch.raw_left_x),
    .raw_y   (in_ch.raw_left_y),
    .raw_t   (in_ch.raw_trigger_left),
    .stick_dz(stick_dz_r),
    .trig_dz (trig_dz_r),
    .done    (lane_done[0]),
    .res     (left_res)
  );

  gic_lane u_lane_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .raw_x   (in_ch.raw_right_x),
    .raw_y   (in_ch.raw_right_y),
    .raw_t   (in_ch.raw_trigger_right),
    .stick_dz(stick_dz_r),
    .trig_dz (trig_dz_r),
    .done    (lane_done[1]),
    .res     (right_res)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_dz_r <= STICK_DZ_RST;
      trig_dz_r  <= TRIG_DZ_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_STICK_DZ: stick_dz_r <= cfg_ch.data;
        CFG_TRIG_DZ:  trig_dz_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // button masks at accept, lanes tracked until merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r  <= '0;
      busy_r      <= 1'b0;
      lane_done_r <= '0;
    end else begin
      if (in_acc) begin
        busy_r      <= 1'b1;
        lane_done_r <= '0;
        disc_r      <= in_ch.action;
        // disconnect clears held buttons and zeroes the whole result
        held_r      <= in_ch.action ? '0 : held_nxt;
        pressed_r   <= in_ch.action ? '0 : held_nxt & ~prev_btn_r;
        released_r  <= in_ch.action ? '0 : prev_btn_r & ~held_nxt;
        prev_btn_r  <= in_ch.action ? '0 : held_nxt;
      end else if (merge) begin
        busy_r      <= 1'b0;
        lane_done_r <= '0;
      end else if (busy_r) begin
        lane_done_r <= done_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (merge) begin
        out_valid_r  <= 1'b1;
        o_held_r     <= held_r;
        o_pressed_r  <= pressed_r;
        o_released_r <= released_r;
        o_left_r     <= disc_r ? '0 : left_res;
        o_right_r    <= disc_r ? '0 : right_res;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.held_mask           = o_held_r;
  assign out_ch.pressed_mask        = o_pressed_r;
  assign out_ch.released_mask       = o_released_r;
  assign out_ch.left_stick_x        = o_left_r.sx;
  assign out_ch.left_stick_y        = o_left_r.sy;
  assign out_ch.right_stick_x       = o_right_r.sx;
  assign out_ch.right_stick_y       = o_right_r.sy;
  assign out_ch.left_trigger_level  = o_left_r.trig;
  assign out_ch.right_trigger_level = o_right_r.trig;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r) else $error("no item in flight after accept");

  a_press_release_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_pressed_r & o_released_r) == '0))
    else $error("button both pressed and released");

  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_pressed_r & ~o_held_r) == '0))
    else $error("pressed button not held");

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> lane_done[1]) else $error("lanes out of step");
`endif

endmodule

>>> dv/gamepad_input_conditioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_tb
// drives poll and disconnect items under several deadzone settings, predicts
// button masks, stick and trigger levels, and checks every result item
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_tb;
  import gic_pkg::*;

  // one poll item as the sender presents it
  typedef struct {
    logic                     action;
    logic [BTN_W-1:0]         buttons;
    logic signed [AXIS_W-1:0] lx, ly, rx, ry, tl, tr;
  } poll_item_t;

  // one conditioned result item
  typedef struct {
    logic [BTN_W-1:0]         held, pressed, released;
    logic signed [AXIS_W-1:0] lx, ly, rx, ry;
    logic [LVL_W-1:0]         tl, tr;
  } cond_item_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int PHASE_ITEMS    = 235;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gic_in_if  in_ch();
  gic_out_if out_ch();
  gic_cfg_if cfg_ch();

  gamepad_input_conditioner u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  poll_item_t pending_polls[$];
  cond_item_t expected_results[$];

  // predictor copies of the deadzones and the held buttons
  int unsigned      stick_dz = STICK_DZ_RST;
  int unsigned      trig_dz  = TRIG_DZ_RST;
  logic [BTN_W-1:0] last_held = '0;

  int  error_count = 0;
  bit  steady_run = 1'b0;  // when set neither side idles
  int  quiet_cycles = 0;
  logic [BTN_W-1:0] gen_buttons = '0;

  // ---------------------------------------------------------------- predictor

  // saturate raw -32768 to -32767
  function automatic int sat_axis(logic signed [AXIS_W-1:0] r);
    int v;
    v = r;
    if (v < -32767) v = -32767;
    return v;
  endfunction

  // round to nearest, ties away from zero, for non-negative operands
  function automatic longint rdiv(longint num, longint den);
    return (num * 2 + den) / (den * 2);
  endfunction

  function automatic int axial_dz(int v, int unsigned d);
    int     a;
    int     den;
    longint r;
    a = (v < 0) ? -v : v;
    den = 32767 - int'(d);
    if (a < int'(d) || den == 0) return 0;
    r = rdiv(longint'(a - int'(d)) * 32767, den);
    if (r > 32767) r = 32767;
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic longint root_round(longint x);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'd1 << 40;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (x > res) res++;
    return res;
  endfunction

  function automatic int scale_comp(int c, longint s, longint m);
    longint a;
    longint r;
    a = (c < 0) ? -c : c;
    r = rdiv(a * s, m);
    if (r > 32767) r = 32767;
    return (c < 0) ? -int'(r) : int'(r);
  endfunction

  task automatic radial_dz(input int x, input int y, output int ox, output int oy);
    longint sq;
    longint m;
    longint s;
    longint d;
    d = stick_dz;
    ox = 0;
    oy = 0;
    sq = longint'(x) * x + longint'(y) * y;
    if (sq < d * d) return;
    m = root_round(sq);
    if (m == 0) return;
    if (d == 32767) begin
      s = (m > d) ? 32767 : 0;
    end else begin
      s = rdiv(((m > d) ? (m - d) : 0) * 32767, 32767 - d);
      if (s > 32767) s = 32767;
    end
    ox = scale_comp(x, s, m);
    oy = scale_comp(y, s, m);
  endtask

  function automatic logic [LVL_W-1:0] trig_level(logic signed [AXIS_W-1:0] r);
    int t;
    int v;
    t = (sat_axis(r) + 32768) >>> 1;
    v = axial_dz(t, trig_dz);
    return (v < 0) ? '0 : LVL_W'(v);
  endfunction

  // expected result of one accepted item, advancing the held buttons
  task automatic condition_poll(input poll_item_t p, output cond_item_t c);
    logic [BTN_W-1:0] held;
    int lx, ly, rx, ry;
    c = '{default: '0};
    if (p.action) begin
      last_held = '0;
      return;
    end
    held = p.buttons & BTN_MASK;
    c.held = held;
    c.pressed = held & ~last_held;
    c.released = last_held & ~held;
    last_held = held;
    lx = axial_dz(sat_axis(p.lx), stick_dz);
    ly = axial_dz(sat_axis(p.ly), stick_dz);
    rx = axial_dz(sat_axis(p.rx), stick_dz);
    ry = axial_dz(sat_axis(p.ry), stick_dz);
    radial_dz(lx, ly, lx, ly);
    radial_dz(rx, ry, rx, ry);
    c.lx = AXIS_W'(lx);
    c.ly = AXIS_W'(ly);
    c.rx = AXIS_W'(rx);
    c.ry = AXIS_W'(ry);
    c.tl = trig_level(p.tl);
    c.tr = trig_level(p.tr);
  endtask

  // ---------------------------------------------------------------- driver

  // the item on the bus is predicted at the edge that accepts it
  always @(posedge clk) begin
    cond_item_t c;
    poll_item_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        p.action = in_ch.action;
        p.buttons = in_ch.button_bits;
        p.lx = in_ch.raw_left_x;
        p.ly = in_ch.raw_left_y;
        p.rx = in_ch.raw_right_x;
        p.ry = in_ch.raw_right_y;
        p.tl = in_ch.raw_trigger_left;
        p.tr = in_ch.raw_trigger_right;
        condition_poll(p, c);
        expected_results.push_back(c);
      end
      // a held item stays on the bus until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_polls.size() != 0 && (steady_run || $urandom_range(0, 99) >= 24)) begin
          p = pending_polls.pop_front();
          in_ch.valid             <= 1'b1;
          in_ch.action            <= p.action;
          in_ch.button_bits       <= p.buttons;
          in_ch.raw_left_x        <= p.lx;
          in_ch.raw_left_y        <= p.ly;
          in_ch.raw_right_x       <= p.rx;
          in_ch.raw_right_y       <= p.ry;
          in_ch.raw_trigger_left  <= p.tl;
          in_ch.raw_trigger_right <= p.tr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    cond_item_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result item at %0t", $realtime);
          error_count++;
        end else begin
          w = expected_results.pop_front();
          if (out_ch.held_mask !== w.held)
            report_mismatch("held_mask", out_ch.held_mask, w.held);
          if (out_ch.pressed_mask !== w.pressed)
            report_mismatch("pressed_mask", out_ch.pressed_mask, w.pressed);
          if (out_ch.released_mask !== w.released)
            report_mismatch("released_mask", out_ch.released_mask, w.released);
          if (out_ch.left_stick_x !== w.lx)
            report_mismatch("left_stick_x", out_ch.left_stick_x, w.lx);
          if (out_ch.left_stick_y !== w.ly)
            report_mismatch("left_stick_y", out_ch.left_stick_y, w.ly);
          if (out_ch.right_stick_x !== w.rx)
            report_mismatch("right_stick_x", out_ch.right_stick_x, w.rx);
          if (out_ch.right_stick_y !== w.ry)
            report_mismatch("right_stick_y", out_ch.right_stick_y, w.ry);
          if (out_ch.left_trigger_level !== w.tl)
            report_mismatch("left_trigger_level", out_ch.left_trigger_level, w.tl);
          if (out_ch.right_trigger_level !== w.tr)
            report_mismatch("right_trigger_level", out_ch.right_trigger_level, w.tr);
        end
      end
      out_ch.ready <= steady_run || ($urandom_range(0, 99) >= 24);
    end
  end

  // ---------------------------------------------------------------- watchdog

  // counts stalled cycles only while work is outstanding
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) ||
        (pending_polls.size() == 0 && expected_results.size() == 0 &&
         in_ch.valid !== 1'b1 && cfg_ch.valid !== 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= DZ_W'(value);
    forever begin
      @(posedge clk);
      if (cfg_ch.valid && cfg_ch.ready) break;
    end
    // out of range indexes change nothing
    if (idx == CFG_STICK_DZ) stick_dz = value & 32'h7fff;
    else if (idx == CFG_TRIG_DZ) trig_dz = value & 32'h7fff;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_poll(input logic act, input logic [BTN_W-1:0] b,
                          input int lx, input int ly, input int rx, input int ry,
                          input int tl, input int tr);
    poll_item_t p;
    p.action = act;
    p.buttons = b;
    p.lx = AXIS_W'(lx);
    p.ly = AXIS_W'(ly);
    p.rx = AXIS_W'(rx);
    p.ry = AXIS_W'(ry);
    p.tl = AXIS_W'(tl);
    p.tr = AXIS_W'(tr);
    pending_polls.push_back(p);
  endtask

  // axis values biased toward extremes and the deadzone edges
  function automatic int pick_axis(int unsigned d);
    int v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = -32767;
          2: v = 32767;
          3: v = 0;
          default: v = 1;
        endcase
      end
      1: begin
        v = int'(d) + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
      2: v = $urandom_range(0, 600) - 300;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic add_random_poll();
    logic act;
    act = ($urandom_range(0, 99) < 5);
    // mostly small changes to the held buttons so edges stay sparse
    if ($urandom_range(0, 2) == 0) gen_buttons = BTN_W'($urandom_range(0, 65535));
    else gen_buttons = gen_buttons ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
    add_poll(act, gen_buttons, pick_axis(stick_dz), pick_axis(stick_dz),
             pick_axis(stick_dz), pick_axis(stick_dz),
             pick_axis(2 * trig_dz), pick_axis(2 * trig_dz));
  endtask

  // sender holds off until every result has come back
  task automatic drain();
    while (pending_polls.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned stick_set[8];
    int unsigned trig_set[8];
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.button_bits = '0;
    in_ch.raw_left_x = '0;
    in_ch.raw_left_y = '0;
    in_ch.raw_right_x = '0;
    in_ch.raw_right_y = '0;
    in_ch.raw_trigger_left = '0;
    in_ch.raw_trigger_right = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_STICK_DZ;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed items under the reset deadzones
    add_poll(1'b0, 16'hffff, 32767, 32767, -32768, -32768, 32767, -32768);
    add_poll(1'b0, 16'h0000, -32767, 0, 0, -32767, -32767, 32767);
    add_poll(1'b0, 16'ha5a5, 6554, 0, 6553, 0, 0, 0);
    add_poll(1'b0, 16'h5a5a, 4700, 4700, -4600, 4600, 3277, -26213);
    add_poll(1'b0, 16'h5a5b, 23170, -23170, 32767, -32767, 100, -100);
    add_poll(1'b1, 16'hffff, 32767, 32767, 32767, 32767, 32767, 32767);
    add_poll(1'b0, 16'h0001, 0, 0, 0, 0, 0, 0);
    add_poll(1'b0, 16'h8000, 1, -1, -32768, 32767, 1, -1);
    drain();

    // zero magnitude and no deadzone
    cfg_write(CFG_STICK_DZ, 0);
    cfg_write(CFG_TRIG_DZ, 0);
    add_poll(1'b0, 16'h0f0f, 0, 0, 0, 1, -32768, 32767);
    add_poll(1'b0, 16'hf0f0, 32767, 32767, -1, 0, 0, -1);
    add_poll(1'b1, 16'h0000, 0, 0, 0, 0, 0, 0);
    drain();

    // full deadzone on sticks and triggers
    cfg_write(CFG_STICK_DZ, 32767);
    cfg_write(CFG_TRIG_DZ, 32767);
    add_poll(1'b0, 16'h1234, 32767, 32767, 32767, 0, 32767, -32768);
    add_poll(1'b0, 16'h4321, -32768, -32768, 23170, 23170, 32767, 32767);
    drain();

    // writes to indexes past the register list are dropped
    cfg_write(2'd2, 100);
    cfg_write(2'd3, 200);
    add_poll(1'b0, 16'hffff, 32767, 1000, -32767, 500, 32767, 0);
    drain();

    stick_set = '{6554, 0, 32767, 1, 32766, 16384, 0, 0};
    trig_set  = '{3277, 32767, 0, 32766, 1, 100, 0, 0};
    stick_set[6] = $urandom_range(0, 32767);
    trig_set[6]  = $urandom_range(0, 32767);
    stick_set[7] = $urandom_range(0, 12000);
    trig_set[7]  = $urandom_range(0, 12000);
    foreach (stick_set[i]) begin
      cfg_write(CFG_STICK_DZ, stick_set[i]);
      cfg_write(CFG_TRIG_DZ, trig_set[i]);
      // one phase runs with no idling on either side
      steady_run = (i == 3);
      repeat (PHASE_ITEMS) add_random_poll();
      drain();
    end
    steady_run = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d result items never arrived", expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
